// ===== hdl/scrf_pkg.sv =====
// Shared types and constants for the sample capture ring.
package scrf_pkg;

    localparam int DEPTH_DEF     = 8192;
    localparam int PIN_COUNT_DEF = 22;
    localparam int MIN_CAPACITY  = 256;
    localparam int CAP_W         = 14;
    localparam int TIME_W        = 64;
    localparam int CNT_W         = 32;
    localparam int OP_W          = 3;
    localparam int STATUS_W      = 2;
    localparam int CFG_IDX_W     = 1;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE    = 3'd0,
        OP_READ      = 3'd1,
        OP_PEEK      = 3'd2,
        OP_CLEAR     = 3'd3,
        OP_RESET_CNT = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_DISABLED = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY = 1'b0,
        CFG_ENABLE   = 1'b1
    } t_cfg_reg;

endpackage

// ===== hdl/scrf_in_if.sv =====
// Op channel into the sample capture ring.
interface scrf_in_if import scrf_pkg::*; #(
    parameter int PIN_COUNT = PIN_COUNT_DEF
);
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      op;
    logic [PIN_COUNT-1:0] pin_levels;
    logic [TIME_W-1:0]    sample_time;

    modport source (output valid, output op, output pin_levels, output sample_time,
                    input ready);
    modport sink   (input valid, input op, input pin_levels, input sample_time,
                    output ready);
endinterface

// ===== hdl/scrf_out_if.sv =====
// Result channel out of the sample capture ring.
interface scrf_out_if import scrf_pkg::*; #(
    parameter int PIN_COUNT = PIN_COUNT_DEF,
    parameter int OCC_W     = $clog2(DEPTH_DEF)
);
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [PIN_COUNT-1:0] out_pins;
    logic [TIME_W-1:0]    out_time;
    logic                 dropped_oldest;
    logic [OCC_W-1:0]     occupancy;
    logic [CNT_W-1:0]     overflow_count;
    logic [CNT_W-1:0]     captured_count;
    logic [CNT_W-1:0]     consumed_count;

    modport source (output valid, output status, output out_pins, output out_time,
                    output dropped_oldest, output occupancy, output overflow_count,
                    output captured_count, output consumed_count, input ready);
    modport sink   (input valid, input status, input out_pins, input out_time,
                    input dropped_oldest, input occupancy, input overflow_count,
                    input captured_count, input consumed_count, output ready);
endinterface

// ===== hdl/sample_capture_ring_fifo.sv =====
// Sample capture ring: one op transaction per cycle while the result register is empty or
// being taken, one result per op. Entries live in a single-port synchronous memory of DEPTH
// words; a read or peek presents the read index in the accept cycle and the registered memory
// word appears with the result in the next cycle; the next op is taken while the result drains.
// The indices, occupancy and counters are registers updated in the accept cycle. Writing
// capacity (clamped to 256..DEPTH) empties the ring; no clearing pass runs after reset.
module sample_capture_ring_fifo import scrf_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int PIN_COUNT = PIN_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CAP_W-1:0]     i_cfg_data,
    scrf_in_if.sink              i_in,
    scrf_out_if.source           o_out
);

    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = IW + 1;
    localparam int ENT_W = PIN_COUNT + TIME_W;

    logic [ENT_W-1:0]    r_mem [DEPTH];
    logic [ENT_W-1:0]    r_rd_data;

    logic [CW-1:0]       r_eff;
    logic                r_en;
    logic [IW-1:0]       r_wr, n_wr;
    logic [IW-1:0]       r_rd, n_rd;
    logic [IW-1:0]       r_occ, n_occ;
    logic [CNT_W-1:0]    r_ovf, n_ovf;
    logic [CNT_W-1:0]    r_cap, n_cap;
    logic [CNT_W-1:0]    r_cons, n_cons;

    logic                r_out_valid;
    t_status             r_status, n_status;
    logic                r_drop, n_drop;
    logic                r_res_read, n_res_read;

    logic                accept;
    logic                mem_we;
    logic                mem_re;
    logic [IW-1:0]       wr_nxt;
    logic [IW-1:0]       rd_nxt;
    logic [CAP_W-1:0]    cap_clamped;

    function automatic logic [IW-1:0] advance(input logic [IW-1:0] idx,
                                              input logic [CW-1:0] eff);
        logic [CW-1:0] n;
        n = {1'b0, idx} + CW'(1);
        return (n >= eff) ? '0 : n[IW-1:0];
    endfunction

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign wr_nxt     = advance(r_wr, r_eff);
    assign rd_nxt     = advance(r_rd, r_eff);

    always_comb begin
        if (i_cfg_data < CAP_W'(MIN_CAPACITY)) begin
            cap_clamped = CAP_W'(MIN_CAPACITY);
        end else if (i_cfg_data > CAP_W'(DEPTH)) begin
            cap_clamped = CAP_W'(DEPTH);
        end else begin
            cap_clamped = i_cfg_data;
        end
    end

    always_comb begin
        n_wr       = r_wr;
        n_rd       = r_rd;
        n_occ      = r_occ;
        n_ovf      = r_ovf;
        n_cap      = r_cap;
        n_cons     = r_cons;
        n_status   = ST_OK;
        n_drop     = 1'b0;
        n_res_read = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        if (accept) begin
            case (t_op'(i_in.op))
                OP_SAMPLE: begin
                    if (!r_en) begin
                        n_status = ST_DISABLED;
                    end else begin
                        mem_we = 1'b1;
                        if (wr_nxt == r_rd) begin
                            // full: drop the oldest entry
                            n_ovf  = r_ovf + CNT_W'(1);
                            n_rd   = rd_nxt;
                            n_drop = 1'b1;
                        end else begin
                            n_occ = r_occ + IW'(1);
                        end
                        n_wr  = wr_nxt;
                        n_cap = r_cap + CNT_W'(1);
                    end
                end
                OP_READ, OP_PEEK: begin
                    if (r_wr == r_rd) begin
                        n_status = ST_EMPTY;
                    end else begin
                        mem_re     = 1'b1;
                        n_res_read = 1'b1;
                        if (t_op'(i_in.op) == OP_READ) begin
                            n_rd   = rd_nxt;
                            n_occ  = r_occ - IW'(1);
                            n_cons = r_cons + CNT_W'(1);
                        end
                    end
                end
                OP_CLEAR: begin
                    n_rd  = r_wr;
                    n_occ = '0;
                end
                OP_RESET_CNT: begin
                    n_ovf  = '0;
                    n_cap  = '0;
                    n_cons = '0;
                end
                default: begin
                end
            endcase
        end
        if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_CAPACITY: begin
                    // new capacity empties the ring, counters stay
                    n_wr  = '0;
                    n_rd  = '0;
                    n_occ = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Entry memory: one write or one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wr] <= {i_in.pin_levels, i_in.sample_time};
        end
        if (mem_re) begin
            r_rd_data <= r_mem[r_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff       <= CW'(DEPTH);
            r_en        <= 1'b0;
            r_wr        <= '0;
            r_rd        <= '0;
            r_occ       <= '0;
            r_ovf       <= '0;
            r_cap       <= '0;
            r_cons      <= '0;
            r_out_valid <= 1'b0;
            r_status    <= ST_OK;
            r_drop      <= 1'b0;
            r_res_read  <= 1'b0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_occ  <= n_occ;
            r_ovf  <= n_ovf;
            r_cap  <= n_cap;
            r_cons <= n_cons;
            if (accept) begin
                r_out_valid <= 1'b1;
                r_status    <= n_status;
                r_drop      <= n_drop;
                r_res_read  <= n_res_read;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    CFG_CAPACITY: begin
                        r_eff <= cap_clamped[CW-1:0];
                    end
                    CFG_ENABLE: begin
                        r_en <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_status;
    assign o_out.out_pins       = r_res_read ? r_rd_data[ENT_W-1:TIME_W] : '0;
    assign o_out.out_time       = r_res_read ? r_rd_data[TIME_W-1:0] : '0;
    assign o_out.dropped_oldest = r_drop;
    assign o_out.occupancy      = r_occ;
    assign o_out.overflow_count = r_ovf;
    assign o_out.captured_count = r_cap;
    assign o_out.consumed_count = r_cons;

endmodule
